// ===== hw/rtl/bea_pkg.sv =====
package bea_pkg;

    localparam int NUM_W    = 14;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 5;

    localparam logic [NUM_W-1:0] LIMIT_RESET = 14'd8192;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [NUM_W-1:0] entry_number;
    } req_t;

    typedef struct packed {
        logic [NUM_W-1:0]    granted_number;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic scan;
        logic free_read;
        logic alloc_commit;
        logic alloc_fail;
        logic free_commit;
        logic free_reject;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic miss;
        logic free_bad;
    } sts_t;

endpackage

// ===== hw/rtl/bitmap_entry_allocator_core.sv =====
// Channel   Handshake               Payload                      Direction
// request   start / busy            req (kind, entry_number)     in
// result    done (one-cycle beat)   rsp (granted_number, status) out
// config    cfg_valid / cfg_ready   cfg_data (entry_limit)       in
//
// After reset, busy stays high while one bitmap word a cycle is cleared, all (BITMAP_BYTES+3)/4 words.
// Allocate reads one bitmap word a cycle, n words in all, at most ceil(limit/32), and stops at
// the first word with a free bit; the result beat reports the grant, or that nothing is free
// (no word is read when the limit is zero).
// Free: a bad number is rejected without a read; otherwise the bit is read and then cleared.
// A new request may be given in the cycle that done is high; results cannot be stalled.
module bitmap_entry_allocator_core #(
    parameter int BITMAP_BYTES = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bea_pkg::req_t             req,
    output logic                      done,
    output bea_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bea_pkg::NUM_W-1:0] cfg_data
);

    import bea_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_kind (req.kind),
        .busy     (busy),
        .cmd      (cmd),
        .sts      (sts)
    );

    bea_dp #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req      (req),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

// ===== hw/rtl/bea_ram.sv =====
module bea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bea_ctrl.sv =====
module bea_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          req_kind,
    output logic          busy,
    output bea_pkg::cmd_t cmd,
    input  bea_pkg::sts_t sts
);

    import bea_pkg::*;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_FREE_RD = 3'd3;
    localparam logic [2:0] S_FREE_WR = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_kind == KIND_FREE) ? S_FREE_RD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (sts.miss)
                begin
                    cmd.alloc_fail = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FREE_RD:
            begin
                if (sts.free_bad)
                begin
                    cmd.free_reject = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.free_read = 1'b1;
                    state_next    = S_FREE_WR;
                end
            end
            S_FREE_WR:
            begin
                cmd.free_commit = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // An accepted request must raise busy in the next cycle, holding off the next one.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Only one result-producing command may fire in a cycle.
    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.alloc_commit, cmd.alloc_fail, cmd.free_commit, cmd.free_reject}))
        else $error("more than one finishing command");

endmodule

// ===== hw/rtl/bea_dp.sv =====
module bea_dp #(
    parameter int BITMAP_BYTES = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bea_pkg::cmd_t                cmd,
    output bea_pkg::sts_t                sts,
    input  bea_pkg::req_t                req,
    input  logic                         cfg_we,
    input  logic [bea_pkg::NUM_W-1:0]    cfg_data,
    output logic                         done,
    output bea_pkg::rsp_t                rsp
);

    import bea_pkg::*;

    localparam int MapBits  = BITMAP_BYTES * 8;
    localparam int MapWords = (BITMAP_BYTES + 3) / 4;
    localparam int AW       = (MapWords > 1) ? $clog2(MapWords) : 1;
    localparam int WIW      = NUM_W - POS_W;
    localparam int CW       = WIW + 1;
    localparam int XW       = (AW > WIW) ? AW : WIW;

    logic [NUM_W-1:0]  limit_reg;
    logic [AW-1:0]     clr_reg;
    logic [CW-1:0]     scan_w_reg;
    logic              data_vld_reg;
    logic [WIW-1:0]    data_w_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              done_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic [NUM_W-1:0]  lim;
    logic [NUM_W:0]    lim_round;
    logic [CW-1:0]     nwords;
    logic [WIW-1:0]    lim_word;
    logic [WORD_W-1:0] last_mask;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] cand;
    logic [POS_W-1:0]  first_idx;
    logic [NUM_W-1:0]  granted;
    logic              issue;
    logic [NUM_W-1:0]  free_bit;
    logic [XW-1:0]     scan_x;
    logic [XW-1:0]     data_x;
    logic [XW-1:0]     free_x;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              we;
    logic [WORD_W-1:0] rdata;

    // The bitmap may be shorter than the configured limit.
    always_comb
    begin
        if (32'(limit_reg) < 32'(MapBits))
        begin
            lim = limit_reg;
        end
        else
        begin
            lim = NUM_W'(MapBits);
        end
    end

    assign lim_round = {1'b0, lim} + (NUM_W + 1)'(31);
    assign nwords    = lim_round[NUM_W:POS_W];
    assign lim_word  = lim[NUM_W-1:POS_W];
    assign last_mask = (WORD_W'(1) << lim[POS_W-1:0]) - WORD_W'(1);

    // Every word read is below the word count, so it is full or the partial last one.
    always_comb
    begin
        if (data_w_reg < lim_word)
        begin
            mask = '1;
        end
        else if (data_w_reg == lim_word)
        begin
            mask = last_mask;
        end
        else
        begin
            mask = '0;
        end
    end

    assign cand = ~rdata & mask;

    always_comb
    begin
        first_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                first_idx = POS_W'(i);
            end
        end
    end

    assign granted  = {data_w_reg, first_idx} + NUM_W'(1);
    assign issue    = cmd.scan && (scan_w_reg < nwords);
    assign free_bit = num_reg - NUM_W'(1);

    assign sts.clr_last = (clr_reg == AW'(MapWords - 1));
    assign sts.hit      = data_vld_reg && (cand != '0);
    assign sts.miss     = !data_vld_reg && (scan_w_reg >= nwords);
    assign sts.free_bad = (num_reg == '0) || (num_reg > lim);

    assign scan_x = XW'(scan_w_reg[WIW-1:0]);
    assign data_x = XW'(data_w_reg);
    assign free_x = XW'(free_bit[NUM_W-1:POS_W]);

    assign raddr = cmd.free_read ? free_x[AW-1:0] : scan_x[AW-1:0];
    assign we    = cmd.clr_step || cmd.alloc_commit || cmd.free_commit;

    always_comb
    begin
        if (cmd.clr_step)
        begin
            waddr = clr_reg;
            wdata = '0;
        end
        else if (cmd.alloc_commit)
        begin
            waddr = data_x[AW-1:0];
            wdata = rdata | (WORD_W'(1) << first_idx);
        end
        else
        begin
            waddr = free_x[AW-1:0];
            wdata = rdata & ~(WORD_W'(1) << free_bit[POS_W-1:0]);
        end
    end

    bea_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MapWords)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.alloc_commit)
        begin
            rsp_next.granted_number = granted;
            rsp_next.status         = ST_OK;
        end
        else if (cmd.alloc_fail)
        begin
            rsp_next.granted_number = '0;
            rsp_next.status         = ST_NO_FREE;
        end
        else if (cmd.free_commit)
        begin
            rsp_next.granted_number = '0;
            rsp_next.status         = ST_OK;
        end
        else if (cmd.free_reject)
        begin
            rsp_next.granted_number = '0;
            rsp_next.status         = ST_RANGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= LIMIT_RESET;
            clr_reg      <= '0;
            scan_w_reg   <= '0;
            data_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                scan_w_reg   <= '0;
                data_vld_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                data_vld_reg <= issue;
                if (issue)
                begin
                    scan_w_reg <= scan_w_reg + CW'(1);
                end
            end
            done_reg <= cmd.alloc_commit || cmd.alloc_fail
                        || cmd.free_commit || cmd.free_reject;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg <= req.entry_number;
        end
        if (cmd.scan && issue)
        begin
            data_w_reg <= scan_w_reg[WIW-1:0];
        end
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // A granted number is 1-based and never beyond the effective limit.
    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |-> (granted != '0) && (granted <= lim))
        else $error("granted number out of range");

    // Only successful allocations carry a nonzero number.
    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_OK)) |-> (rsp.granted_number == '0))
        else $error("nonzero number with failing status");

endmodule
